// ----- rtl/balu_pkg.sv -----
// Package for the byte ALU with flags: opcode codes, flag layout and the
// packed transfer types of the input and result channels. No dependencies.
`default_nettype none

package balu_pkg;

  // Opcode codes carried in the opcode field.
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_ADC = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_SBC = 4'd3;
  localparam logic [3:0] OP_AND = 4'd4;
  localparam logic [3:0] OP_XOR = 4'd5;
  localparam logic [3:0] OP_OR  = 4'd6;
  localparam logic [3:0] OP_CP  = 4'd7;
  localparam logic [3:0] OP_INC = 4'd8;
  localparam logic [3:0] OP_DEC = 4'd9;
  localparam logic [3:0] OP_DAA = 4'd10;
  localparam logic [3:0] OP_CPL = 4'd11;
  localparam logic [3:0] OP_SCF = 4'd12;
  localparam logic [3:0] OP_CCF = 4'd13;

  // Decimal-adjust constants.
  localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
  localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
  localparam logic [7:0] DAA_BCD_MAX  = 8'h99;
  localparam logic [3:0] DAA_DIGIT_MAX = 4'd9;

  // Status flags: zero, subtract, half-carry, carry.
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } balu_flags_t;

  // One input transfer.
  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] first_operand;
    logic [7:0] second_operand;
  } balu_in_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] result_byte;
    logic       writes_back;
    logic       zero_out;
    logic       subtract_out;
    logic       half_carry_out;
    logic       carry_out;
  } balu_out_t;

endpackage

`default_nettype wire

// ----- rtl/byte_alu_with_flags_top.sv -----
// Top level of the byte ALU with flags: input register, ALU datapath,
// status flag register and result register. Depends on balu_pkg, balu_core.
`default_nettype none

// Usage:
// - Input channel in_valid/in_ready/in_data carries opcode and two operand
//   bytes. Result channel out_valid/out_ready/out_data carries the result
//   byte, the write-back bit and the four new flags, one result per input.
// - An accepted item is held in the input register, passes the ALU
//   logic and lands in the result register, which drives out_valid.
// - Throughput is one item per cycle while results are taken. The status
//   flag register is written at the same edge that loads the result
//   register, so the next item in the input register sees the updated
//   flags with no bubble.
// - When the receiver stalls, the result register holds; the input
//   register still takes one more item, then in_ready drops until the
//   result is taken.
// - Reset (rst_n low, synchronous) empties both registers and clears all
//   four flags.
module byte_alu_with_flags_top import balu_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  wire balu_in_t in_data,
  output logic      out_valid,
  input  wire       out_ready,
  output balu_out_t out_data
);

  logic        in_valid_r;
  logic        in_valid_nxt;
  balu_in_t    in_data_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  balu_out_t   out_data_r;
  balu_flags_t flags_r;
  balu_out_t   alu_res;
  balu_flags_t alu_flags;
  logic        out_free;
  logic        advance;

  // Datapath between the input and result registers.
  balu_core u_core (
    .op_in     (in_data_r),
    .flags_in  (flags_r),
    .res_out   (alu_res),
    .flags_out (alu_flags)
  );

  // Handshake: the result register frees up when empty or taken.
  assign out_free      = !out_valid_r || out_ready;
  assign advance       = in_valid_r && out_free;
  assign in_ready      = !in_valid_r || out_free;
  assign in_valid_nxt  = (in_valid && in_ready) || (in_valid_r && !out_free);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        flags_r <= alu_flags;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= alu_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/balu_core.sv -----
// Combinational datapath of the byte ALU: computes result byte, write-back
// flag and new status flags from one operation. Depends on balu_pkg.
`default_nettype none

module balu_core import balu_pkg::*; (
  input  wire balu_in_t    op_in,
  input  wire balu_flags_t flags_in,
  output balu_out_t        res_out,
  output balu_flags_t      flags_out
);

  logic [3:0] op;
  logic [7:0] a;
  logic [7:0] b;
  logic       cin;
  logic [8:0] sum9;
  logic [4:0] sum_lo;
  logic [8:0] diff9;
  logic [4:0] diff_lo;
  logic [7:0] daa_adj;
  logic       daa_c;
  logic [7:0] daa_r;
  logic [7:0] r;
  logic       wb;
  balu_flags_t f;

  assign op = op_in.opcode;
  assign a  = op_in.first_operand;
  assign b  = op_in.second_operand;

  // Carry or borrow in is used only by the with-carry opcodes.
  assign cin = ((op == OP_ADC) || (op == OP_SBC)) ? flags_in.c : 1'b0;

  // Nine-bit sum and difference; the top bits give carry and borrow.
  assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, cin};
  assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
  assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, cin};
  assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};

  // Decimal adjust: correction term and new carry depend on the last
  // operation's direction.
  always_comb begin
    daa_adj = 8'd0;
    daa_c   = flags_in.c;
    if (!flags_in.n) begin
      if (flags_in.c || (a > DAA_BCD_MAX)) begin
        daa_adj = daa_adj | DAA_HIGH_ADJ;
        daa_c   = 1'b1;
      end
      if (flags_in.h || (a[3:0] > DAA_DIGIT_MAX)) begin
        daa_adj = daa_adj | DAA_LOW_ADJ;
      end
      daa_r = a + daa_adj;
    end else begin
      if (flags_in.c) begin
        daa_adj = daa_adj | DAA_HIGH_ADJ;
      end
      if (flags_in.h) begin
        daa_adj = daa_adj | DAA_LOW_ADJ;
      end
      daa_r = a - daa_adj;
    end
  end

  // Operation select.
  always_comb begin
    r  = a;
    wb = 1'b1;
    f  = flags_in;
    unique case (op)
      OP_ADD, OP_ADC: begin
        r = sum9[7:0];
        f = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: sum_lo[4], c: sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        f = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: diff_lo[4], c: diff9[8]};
        if (op == OP_CP) begin
          wb = 1'b0;
        end else begin
          r = diff9[7:0];
        end
      end
      OP_AND: begin
        r = a & b;
        f = '{z: ((a & b) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_XOR: begin
        r = a ^ b;
        f = '{z: ((a ^ b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_OR: begin
        r = a | b;
        f = '{z: ((a | b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_INC: begin
        r = a + 8'd1;
        f = '{z: (a == 8'hFF), n: 1'b0, h: (a[3:0] == 4'hF), c: flags_in.c};
      end
      OP_DEC: begin
        r = a - 8'd1;
        f = '{z: (a == 8'h01), n: 1'b1, h: (a[3:0] == 4'h0), c: flags_in.c};
      end
      OP_DAA: begin
        r = daa_r;
        f = '{z: (daa_r == 8'd0), n: flags_in.n, h: 1'b0, c: daa_c};
      end
      OP_CPL: begin
        r = ~a;
        f = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: flags_in.c};
      end
      OP_SCF: begin
        wb = 1'b0;
        f  = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      OP_CCF: begin
        wb = 1'b0;
        f  = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: ~flags_in.c};
      end
      default: begin
        // Unused opcodes leave everything unchanged.
        wb = 1'b0;
      end
    endcase
  end

  assign flags_out = f;

  always_comb begin
    res_out.result_byte    = r;
    res_out.writes_back    = wb;
    res_out.zero_out       = f.z;
    res_out.subtract_out   = f.n;
    res_out.half_carry_out = f.h;
    res_out.carry_out      = f.c;
  end

endmodule

`default_nettype wire
